// ===== rtl/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Power-of-two box downsampler package
// Shared sizes, register map, and the beat structures that pass between the
// front end, the command queue and the accumulation back end.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int SAMPLE_BITS   = 16;
    localparam int SIZE_BITS     = 13;
    localparam int POS_BITS      = 12;
    localparam int SHIFT_BITS    = 4;
    localparam int SHIFT_LIMIT   = 15;
    localparam int LINE_DEPTH    = MAX_WIDTH / 2;
    localparam int OX_BITS       = $clog2(LINE_DEPTH);
    localparam int SUM_BITS      = 40;

    localparam int CMDQ_DEPTH    = 4;
    localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH    = 4;
    localparam int RESQ_PTR_BITS = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_BITS = $clog2(RESQ_DEPTH + 1);

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;

    typedef struct packed {
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
        logic [SIZE_BITS-1:0] max_width;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic [OX_BITS-1:0]     ox;
        logic [SHIFT_BITS-1:0]  shift;
        logic                   first;
        logic                   last;
        logic                   frame_last;
        logic [SIZE_BITS-1:0]   dw;
        logic [SIZE_BITS-1:0]   dh;
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic                   frame_last;
        logic [SIZE_BITS-1:0]   scaled_width;
        logic [SIZE_BITS-1:0]   scaled_height;
    } res_t;

endpackage

// ===== rtl/pbd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module pbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pbd_front.sv =====
// ----------------------------------------------------------------------------
// Downsampler front end
// Tracks the raster position, picks the scale factor at frame start and
// classifies each accepted pixel into a command for the back end.
// ----------------------------------------------------------------------------
module pbd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbd_pkg::cfg_t                 cfg,
    input  logic                          push,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0] red_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0] green_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0] blue_in,
    input  logic                          cmdq_full,
    output logic                          cmd_push,
    output pbd_pkg::cmd_t                 cmd
);
    import pbd_pkg::*;

    logic [POS_BITS-1:0]   col_reg, col_next;
    logic [POS_BITS-1:0]   row_reg, row_next;
    logic [SHIFT_BITS-1:0] shift_reg, shift_next;

    logic                  accept;
    logic                  at_origin;
    logic [SHIFT_BITS-1:0] shift_calc;
    logic [SHIFT_BITS-1:0] shift_cur;
    logic [POS_BITS-1:0]   ox_full;
    logic [POS_BITS-1:0]   oy_full;
    logic [SIZE_BITS-1:0]  dw;
    logic [SIZE_BITS-1:0]  dh;
    logic [POS_BITS-1:0]   f1;
    logic                  in_range;
    logic [SIZE_BITS-1:0]  col_inc;
    logic [SIZE_BITS-1:0]  row_inc;

    assign accept    = push && !cmdq_full;
    assign at_origin = (col_reg == '0) && (row_reg == '0);

    // Smallest shift whose reduced width fits; the compares are independent.
    always_comb
    begin
        shift_calc = SHIFT_BITS'(SHIFT_LIMIT);
        for (int k = SHIFT_LIMIT - 1; k >= 0; k--)
        begin
            if ((cfg.width >> k) <= cfg.max_width)
            begin
                shift_calc = SHIFT_BITS'(k);
            end
        end
        if (cfg.max_width == '0)
        begin
            shift_calc = '0;
        end
    end

    assign shift_cur = at_origin ? shift_calc : shift_reg;
    assign ox_full   = col_reg >> shift_cur;
    assign oy_full   = row_reg >> shift_cur;
    assign dw        = cfg.width >> shift_cur;
    assign dh        = cfg.height >> shift_cur;
    assign f1        = POS_BITS'((16'd1 << shift_cur) - 16'd1);
    assign in_range  = ({1'b0, ox_full} < dw) && ({1'b0, oy_full} < dh);

    always_comb
    begin
        cmd.red        = red_in;
        cmd.green      = green_in;
        cmd.blue       = blue_in;
        cmd.ox         = ox_full[OX_BITS-1:0];
        cmd.shift      = shift_cur;
        cmd.first      = ((col_reg & f1) == '0) && ((row_reg & f1) == '0);
        cmd.last       = ((col_reg & f1) == f1) && ((row_reg & f1) == f1);
        cmd.frame_last = ({1'b0, ox_full} == dw - 1'b1) && ({1'b0, oy_full} == dh - 1'b1);
        cmd.dw         = dw;
        cmd.dh         = dh;
    end

    assign cmd_push = accept && in_range;

    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        shift_next = shift_reg;
        if (accept)
        begin
            shift_next = shift_cur;
            if (col_inc >= cfg.width)
            begin
                col_next = '0;
                row_next = (row_inc >= cfg.height) ? '0 : row_inc[POS_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[POS_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== rtl/pbd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Downsampler command queue
// Short first-in first-out store of classified pixels between the front end
// and the back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module pbd_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pbd_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output pbd_pkg::cmd_t dout,
    output logic          empty
);
    import pbd_pkg::*;

    cmd_t                     entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_BITS-1:0] count_reg, count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full    = (count_reg == CMDQ_CNT_BITS'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/pbd_back.sv =====
// ----------------------------------------------------------------------------
// Downsampler back end
// Read-modify-write of the accumulator line store with write-back forwarding,
// the final scaling shift, and the result queue seen at the output.
// ----------------------------------------------------------------------------
module pbd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmdq_empty,
    input  pbd_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output pbd_pkg::res_t res
);
    import pbd_pkg::*;

    localparam int LINE_BITS = 3 * SUM_BITS;

    // Stage one: the command whose line-store read is in flight.
    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;

    // Most recent line-store write, used to forward over a read that raced it.
    logic                     wb_valid_reg;
    logic [OX_BITS-1:0]       wb_ox_reg;
    logic [LINE_BITS-1:0]     wb_sum_reg;

    res_t                     resq_reg [RESQ_DEPTH];
    logic [RESQ_PTR_BITS-1:0] resq_wr_reg, resq_wr_next;
    logic [RESQ_PTR_BITS-1:0] resq_rd_reg, resq_rd_next;
    logic [RESQ_CNT_BITS-1:0] resq_cnt_reg, resq_cnt_next;

    logic [LINE_BITS-1:0]     ram_rdata;
    logic [LINE_BITS-1:0]     base;
    logic [SUM_BITS-1:0]      sum_r;
    logic [SUM_BITS-1:0]      sum_g;
    logic [SUM_BITS-1:0]      sum_b;
    logic [LINE_BITS-1:0]     sum_line;
    logic                     line_we;
    logic [SHIFT_BITS:0]      avg_shift;
    logic                     res_push;
    logic                     res_pop;
    res_t                     res_new;

    // A command leaves the queue only when its possible result has room.
    assign cmd_pop = !cmdq_empty
        && ((RESQ_CNT_BITS + 1)'(resq_cnt_reg) + (RESQ_CNT_BITS + 1)'(s1_valid_reg)
            < (RESQ_CNT_BITS + 1)'(RESQ_DEPTH));

    pbd_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_cmd_reg.ox),
        .wdata (sum_line),
        .re    (cmd_pop),
        .raddr (cmd.ox),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (s1_cmd_reg.first)
        begin
            base = '0;
        end
        else if (wb_valid_reg && (wb_ox_reg == s1_cmd_reg.ox))
        begin
            base = wb_sum_reg;
        end
        else
        begin
            base = ram_rdata;
        end
    end

    assign sum_r    = base[3*SUM_BITS-1:2*SUM_BITS] + SUM_BITS'(s1_cmd_reg.red);
    assign sum_g    = base[2*SUM_BITS-1:SUM_BITS] + SUM_BITS'(s1_cmd_reg.green);
    assign sum_b    = base[SUM_BITS-1:0] + SUM_BITS'(s1_cmd_reg.blue);
    assign sum_line = {sum_r, sum_g, sum_b};

    // Pass-through pixels never touch the line store.
    assign line_we   = s1_valid_reg && (s1_cmd_reg.shift != '0);
    assign avg_shift = {s1_cmd_reg.shift, 1'b0};

    always_comb
    begin
        res_new.red           = SAMPLE_BITS'(sum_r >> avg_shift);
        res_new.green         = SAMPLE_BITS'(sum_g >> avg_shift);
        res_new.blue          = SAMPLE_BITS'(sum_b >> avg_shift);
        res_new.frame_last    = s1_cmd_reg.frame_last;
        res_new.scaled_width  = s1_cmd_reg.dw;
        res_new.scaled_height = s1_cmd_reg.dh;
    end

    assign res_push = s1_valid_reg && s1_cmd_reg.last;
    assign empty    = (resq_cnt_reg == '0);
    assign res_pop  = pop && !empty;
    assign res      = resq_reg[resq_rd_reg];

    always_comb
    begin
        resq_wr_next  = res_push ? resq_wr_reg + 1'b1 : resq_wr_reg;
        resq_rd_next  = res_pop ? resq_rd_reg + 1'b1 : resq_rd_reg;
        resq_cnt_next = resq_cnt_reg;
        if (res_push && !res_pop)
        begin
            resq_cnt_next = resq_cnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            resq_cnt_next = resq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_cmd_reg <= cmd;
        end
        if (line_we)
        begin
            wb_ox_reg  <= s1_cmd_reg.ox;
            wb_sum_reg <= sum_line;
        end
        if (res_push)
        begin
            resq_reg[resq_wr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            resq_wr_reg  <= '0;
            resq_rd_reg  <= '0;
            resq_cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd_pop;
            wb_valid_reg <= wb_valid_reg || line_we;
            resq_wr_reg  <= resq_wr_next;
            resq_rd_reg  <= resq_rd_next;
            resq_cnt_reg <= resq_cnt_next;
        end
    end

endmodule

// ===== rtl/power_of_two_box_downsampler.sv =====
// ----------------------------------------------------------------------------
// Power-of-two box downsampler
// Averages square blocks of RGB pixels of a raster frame down to an output
// width that fits a programmed limit.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock while its command queue has room. In
// pass-through it also delivers one result beat per clock, and with a factor
// F one beat per completed block, so a full frame streams through without
// gaps while the receiver keeps popping. At the first pixel of each frame it
// picks the smallest power-of-two factor F for which the frame width divided
// by F is no more than max_width (a max_width of zero passes pixels through
// unchanged). Each F-by-F block is summed per channel in a 2048-entry line
// store and the sums are shifted right by 2*log2(F), so averages truncate;
// blocks cut off at the right or bottom edge are dropped. A block's last
// pixel passes the command queue and the line-store read, then the add,
// write-back and result queue entry, and its result is then on the result
// ports. The one-beat-per-clock rate, held while no queue stalls, is set by
// the line store's read-modify-write loop, which forwards the previous write
// over a read that raced it. The line store needs no clearing after reset,
// since the first pixel of every block overwrites its entry.
// Registers sit at byte addresses 0 (image_width), 4 (image_height) and
// 8 (max_width) and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
module power_of_two_box_downsampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pbd_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pbd_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pbd_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    // Pixel input
    input  logic                                 push,
    output logic                                 full,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]      red_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]      green_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]      blue_in,
    // Result output
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pbd_pkg::SAMPLE_BITS-1:0]      red_out,
    output logic [pbd_pkg::SAMPLE_BITS-1:0]      green_out,
    output logic [pbd_pkg::SAMPLE_BITS-1:0]      blue_out,
    output logic                                 frame_last,
    output logic [pbd_pkg::SIZE_BITS-1:0]        scaled_width,
    output logic [pbd_pkg::SIZE_BITS-1:0]        scaled_height
);
    import pbd_pkg::*;

    logic [SIZE_BITS-1:0] image_width_reg;
    logic [SIZE_BITS-1:0] image_height_reg;
    logic [SIZE_BITS-1:0] max_width_reg;

    logic       cfg_write;
    logic [1:0] reg_index;
    cfg_t       cfg;
    cmd_t       front_cmd;
    cmd_t       queue_cmd;
    logic       front_push;
    logic       cmdq_full;
    logic       cmdq_empty;
    logic       back_pop;
    res_t       res;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= SIZE_BITS'(1);
            image_height_reg <= SIZE_BITS'(1);
            max_width_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[SIZE_BITS-1:0];
                REG_MAX_WIDTH:    max_width_reg    <= pwdata[SIZE_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(image_height_reg);
            REG_MAX_WIDTH:    prdata = APB_DATA_BITS'(max_width_reg);
            default:          prdata = '0;
        endcase
    end

    // A size of zero behaves as one, and sizes beyond the largest supported
    // frame of 4096 by 4096 are clamped to it.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            cfg.width = SIZE_BITS'(1);
        end
        else if (image_width_reg > SIZE_BITS'(MAX_WIDTH))
        begin
            cfg.width = SIZE_BITS'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = image_width_reg;
        end

        if (image_height_reg == '0)
        begin
            cfg.height = SIZE_BITS'(1);
        end
        else if (image_height_reg > SIZE_BITS'(MAX_HEIGHT))
        begin
            cfg.height = SIZE_BITS'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = image_height_reg;
        end

        cfg.max_width = max_width_reg;
    end

    // The front end takes every pixel it is offered while the queue has room;
    // pixels outside any complete block are counted and then dropped.
    pbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cmdq_full (cmdq_full),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    assign full = cmdq_full;

    pbd_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .full  (cmdq_full),
        .pop   (back_pop),
        .dout  (queue_cmd),
        .empty (cmdq_empty)
    );

    // The back end accumulates into the line store and queues finished blocks.
    pbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .cmd        (queue_cmd),
        .cmd_pop    (back_pop),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    assign red_out       = res.red;
    assign green_out     = res.green;
    assign blue_out      = res.blue;
    assign frame_last    = res.frame_last;
    assign scaled_width  = res.scaled_width;
    assign scaled_height = res.scaled_height;

endmodule

// ===== tb/box_average_checker.sv =====
// ----------------------------------------------------------------------------
// Box average checker
// Watches the configuration port and both queue sides of the downsampler,
// works out the averaged pixel that each completed block of accepted input
// beats should produce and compares each popped result beat with the oldest
// outstanding one.
module box_average_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pbd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pbd_pkg::APB_DATA_BITS-1:0]  pwdata,
    input  logic                               pready,
    input  logic                               push,
    input  logic                               full,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    red_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    green_in,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    blue_in,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    red_out,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    green_out,
    input  logic [pbd_pkg::SAMPLE_BITS-1:0]    blue_out,
    input  logic                               frame_last,
    input  logic [pbd_pkg::SIZE_BITS-1:0]      scaled_width,
    input  logic [pbd_pkg::SIZE_BITS-1:0]      scaled_height,
    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pbd_pkg::*;

    logic [SIZE_BITS-1:0]  cfg_width;
    logic [SIZE_BITS-1:0]  cfg_height;
    logic [SIZE_BITS-1:0]  cfg_max_width;
    logic [POS_BITS-1:0]   col_pos;
    logic [POS_BITS-1:0]   row_pos;
    logic [SHIFT_BITS-1:0] block_shift;
    logic [SUM_BITS-1:0]   red_acc   [LINE_DEPTH];
    logic [SUM_BITS-1:0]   green_acc [LINE_DEPTH];
    logic [SUM_BITS-1:0]   blue_acc  [LINE_DEPTH];
    res_t                  averages_due [$];

    function automatic int unsigned clamp_dim(input logic [SIZE_BITS-1:0] v,
                                              input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // One accepted pixel: updates the position, the latched factor and the
    // line of block sums, and queues an average when a block completes.
    task automatic predict_pixel(input logic [15:0] r, input logic [15:0] g,
                                 input logic [15:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned dw;
        int unsigned dh;
        int unsigned f1;
        int unsigned ox;
        int unsigned oy;
        res_t        avg;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (col_pos == 0 && row_pos == 0)
        begin
            s = 0;
            while (cfg_max_width != 0 && (w >> s) > cfg_max_width && s < SHIFT_LIMIT)
                s++;
            block_shift = SHIFT_BITS'(s);
        end
        s  = 32'(block_shift);
        dw = w >> s;
        dh = h >> s;
        f1 = (32'd1 << s) - 1;
        if (s == 0)
        begin
            if (col_pos < w && row_pos < h)
            begin
                avg.red           = r;
                avg.green         = g;
                avg.blue          = b;
                avg.frame_last    = (col_pos == w - 1 && row_pos == h - 1);
                avg.scaled_width  = SIZE_BITS'(w);
                avg.scaled_height = SIZE_BITS'(h);
                averages_due      = {averages_due, avg};
            end
        end
        else
        begin
            ox = 32'(col_pos) >> s;
            oy = 32'(row_pos) >> s;
            if (ox < dw && oy < dh && ox < LINE_DEPTH)
            begin
                if ((col_pos & f1) == 0 && (row_pos & f1) == 0)
                begin
                    red_acc[ox]   = SUM_BITS'(r);
                    green_acc[ox] = SUM_BITS'(g);
                    blue_acc[ox]  = SUM_BITS'(b);
                end
                else
                begin
                    red_acc[ox]   = red_acc[ox] + r;
                    green_acc[ox] = green_acc[ox] + g;
                    blue_acc[ox]  = blue_acc[ox] + b;
                end
                if ((col_pos & f1) == f1 && (row_pos & f1) == f1)
                begin
                    avg.red           = 16'(red_acc[ox] >> (2 * s));
                    avg.green         = 16'(green_acc[ox] >> (2 * s));
                    avg.blue          = 16'(blue_acc[ox] >> (2 * s));
                    avg.frame_last    = (ox == dw - 1 && oy == dh - 1);
                    avg.scaled_width  = SIZE_BITS'(dw);
                    avg.scaled_height = SIZE_BITS'(dh);
                    averages_due      = {averages_due, avg};
                end
            end
        end
        if (col_pos + 32'd1 >= w)
        begin
            col_pos = '0;
            row_pos = (row_pos + 32'd1 >= h) ? '0 : row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            cfg_width     = SIZE_BITS'(1);
            cfg_height    = SIZE_BITS'(1);
            cfg_max_width = '0;
            col_pos       = '0;
            row_pos       = '0;
            block_shift   = '0;
            averages_due.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (averages_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, got %0h %0h %0h",
                             $time, red_out, green_out, blue_out);
                end
                else
                begin
                    want = averages_due.pop_front();
                    check_field("red_out", want.red, red_out);
                    check_field("green_out", want.green, green_out);
                    check_field("blue_out", want.blue, blue_out);
                    check_field("frame_last", 16'(want.frame_last), 16'(frame_last));
                    check_field("scaled_width", 16'(want.scaled_width),
                                16'(scaled_width));
                    check_field("scaled_height", 16'(want.scaled_height),
                                16'(scaled_height));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_IMAGE_WIDTH:  cfg_width     = pwdata[SIZE_BITS-1:0];
                    REG_IMAGE_HEIGHT: cfg_height    = pwdata[SIZE_BITS-1:0];
                    REG_MAX_WIDTH:    cfg_max_width = pwdata[SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_pixel(red_in, green_in, blue_in);
            outstanding = averages_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Power-of-two box downsampler testbench
// Drives raster frames, some of them cut short, through the downsampler
// under a series of frame sizes and width limits, with random back-pressure
// on both queue sides; the box average checker checks every result beat.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbd_pkg::*;

    // Pixels to send in all, directed and extreme frames included; the last
    // setting may run a little past this.
    localparam int ITEMS        = 1850;
    // A pixel that produces nothing still passes the command queue and the
    // back end's command stage, so draining ends with DRAIN_CYCLES idle clocks
    // after the last result to let such pixels work through.
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_EXTREMES   = 8;

    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     push     = 1'b0;
    logic                     full;
    logic [SAMPLE_BITS-1:0]   red_in   = '0;
    logic [SAMPLE_BITS-1:0]   green_in = '0;
    logic [SAMPLE_BITS-1:0]   blue_in  = '0;
    logic                     empty;
    logic                     pop      = 1'b0;
    logic [SAMPLE_BITS-1:0]   red_out;
    logic [SAMPLE_BITS-1:0]   green_out;
    logic [SAMPLE_BITS-1:0]   blue_out;
    logic                     frame_last;
    logic [SIZE_BITS-1:0]     scaled_width;
    logic [SIZE_BITS-1:0]     scaled_height;

    int mismatches;
    int outstanding;
    int cycles    = 0;
    int gap_pct   = 0;
    int stall_pct = 0;

    // Pixel beats taken by the block so far.
    int unsigned sent = 0;

    // Register values currently programmed, as written (before any clamping).
    int unsigned cur_width  = 1;
    int unsigned cur_height = 1;

    // Extreme settings: zero sizes, oversize width with the largest width
    // limit, oversize height in pass-through, the widest frame at an exact fit
    // of factor two, the largest factor on a frame too short to give any
    // output, one big block of saturated samples, and a frame that drops a
    // partial column and row. A non-zero count sends only that many pixels of
    // a huge frame; the frame is then cut short by shrinking it to one pixel.
    int unsigned ext_width  [N_EXTREMES] = '{0, 8191, 1,    4096, 8191, 16, 20,   9};
    int unsigned ext_height [N_EXTREMES] = '{0, 1,    8191, 2,    1,    16, 3,    7};
    int unsigned ext_limit  [N_EXTREMES] = '{0, 8191, 0,    2048, 1,    1,  8191, 2};
    int unsigned ext_style  [N_EXTREMES] = '{0, 0,    0,    0,    0,    1,  3,    2};
    int unsigned ext_count  [N_EXTREMES] = '{0, 64,   64,   64,   64,   0,  0,    0};

    power_of_two_box_downsampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .empty         (empty),
        .pop           (pop),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .frame_last    (frame_last),
        .scaled_width  (scaled_width),
        .scaled_height (scaled_height)
    );

    box_average_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .empty         (empty),
        .pop           (pop),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .frame_last    (frame_last),
        .scaled_width  (scaled_width),
        .scaled_height (scaled_height),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a run that hangs, or loses result beats, ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random; pop is changed only on falling edges,
    // so the value seen at each rising edge is settled.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // Frame dimension as the block sees it: zero acts as one and anything
    // above the line limit is clamped to it.
    function automatic int unsigned frame_dim(input int unsigned v, input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Sample for a frame of the given content style: random, all full scale,
    // all zero, or alternating between the two extremes.
    function automatic logic [15:0] frame_sample(input int unsigned style, input int unsigned i);
        case (style)
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return i[0] ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mode 0: light sender gaps with heavy receiver stalls. Mode 1: the
    // reverse. Mode 2: both sides run flat out.
    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:       begin gap_pct = 7;  stall_pct = 52; end
            1:       begin gap_pct = 52; stall_pct = 7;  end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Offers one pixel beat and returns on the falling edge after it has
    // been taken. Push stays high across back-to-back beats.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (full);
        sent++;
        @(negedge clk);
    endtask

    // Sends one complete frame for the registers currently programmed, so
    // that the raster position is back at the top left afterwards.
    task automatic send_frame(input int unsigned style);
        int unsigned n;
        n = frame_dim(cur_width, MAX_WIDTH) * frame_dim(cur_height, MAX_HEIGHT);
        for (int unsigned i = 0; i < n; i++)
            send_pixel(frame_sample(style, i), frame_sample(style, i + 1),
                       frame_sample(style, i));
    endtask

    // Lets every outstanding result beat out, then gives pixels that give
    // no result time to leave the pipeline as well.
    task automatic drain_results();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write: setup beat, access beat, then an idle beat with psel low
    // so that psel is never dropped and raised on the same edge. The unused upper
    // data bits carry junk, which the block must ignore.
    task automatic write_reg(input logic [1:0] idx, input logic [SIZE_BITS-1:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:SIZE_BITS], value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input int unsigned w, input int unsigned h,
                                 input int unsigned limit);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, SIZE_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, SIZE_BITS'(h));
        write_reg(REG_MAX_WIDTH, SIZE_BITS'(limit));
        cur_width  = w;
        cur_height = h;
    endtask

    initial
    begin : stimulus
        int unsigned rw;
        int unsigned rh;
        int unsigned rm;
        int unsigned dim;
        int unsigned frames;
        int unsigned style;
        int unsigned phase;
        int unsigned ext_idx;
        logic [15:0] pattern [8];

        pattern = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                    16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
        phase    = 0;
        ext_idx  = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The reset registers give one-pixel frames in
        // pass-through, each beat being the last of its frame.
        set_idling(0);
        send_pixel(16'h0000, 16'hFFFF, 16'h8000);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);

        // A 5x3 pass-through frame, stopped part way through its second row
        // at column 2. The width then shrinks to 2 under the running frame:
        // the factor stays latched, the pixel at column 2 is now past the
        // edge and gives nothing, and the last row finishes at the new width.
        // The new width limit only takes hold at the next frame.
        apply_setting(5, 3, 0);
        for (int i = 0; i < 7; i++)
            send_pixel(pattern[i], pattern[(i + 3) % 8], pattern[(i + 5) % 8]);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, SIZE_BITS'(2));
        write_reg(REG_MAX_WIDTH, SIZE_BITS'(1));
        for (int i = 0; i < 3; i++)
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom));

        // Two 2x2 blocks of alternating full-scale and zero samples.
        apply_setting(4, 2, 2);
        send_frame(3);

        // Random part. Every second setting is one of the extremes until
        // they are used up; the rest are mostly small frames so that many
        // settings are visited.
        while (sent < ITEMS || ext_idx < N_EXTREMES)
        begin
            set_idling((sent * 3 / ITEMS > 2) ? 2 : sent * 3 / ITEMS);
            if (ext_idx < N_EXTREMES && (phase % 2 == 1 || sent >= ITEMS))
            begin
                apply_setting(ext_width[ext_idx], ext_height[ext_idx], ext_limit[ext_idx]);
                if (ext_count[ext_idx] == 0)
                    send_frame(ext_style[ext_idx]);
                else
                begin
                    for (int unsigned i = 0; i < ext_count[ext_idx]; i++)
                        send_pixel(frame_sample(ext_style[ext_idx], i),
                                   frame_sample(ext_style[ext_idx], i + 1),
                                   frame_sample(ext_style[ext_idx], i));
                    // With a one-pixel frame the next pixel lies past the
                    // edge, gives nothing and brings the raster back to the
                    // top left.
                    apply_setting(1, 1, 0);
                    send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
                end
                ext_idx++;
            end
            else
            begin
                rw = $urandom_range(99);
                if (rw < 70)
                    rw = $urandom_range(24, 1);
                else if (rw < 90)
                    rw = $urandom_range(160, 25);
                else if (rw < 95)
                    rw = 0;
                else
                    rw = $urandom_range(400, 161);
                dim = frame_dim(rw, MAX_WIDTH);
                rh = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
                if (dim * frame_dim(rh, MAX_HEIGHT) > 400)
                    rh = (400 / dim == 0) ? 1 : 400 / dim;
                rm = $urandom_range(99);
                if (rm < 25)
                    rm = 0;
                else if (rm < 80)
                    rm = $urandom_range(dim, 1);
                else if (rm < 90)
                    rm = $urandom_range(8191, dim);
                else
                    rm = 1;
                frames = $urandom_range(2, 1);
                apply_setting(rw, rh, rm);
                for (int unsigned f = 0; f < frames; f++)
                begin
                    style = ($urandom_range(99) < 85) ? 0 : $urandom_range(3, 1);
                    send_frame(style);
                end
            end
            phase++;
        end

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pbd_pkg.sv
rtl/pbd_ram.sv
rtl/pbd_front.sv
rtl/pbd_cmd_queue.sv
rtl/pbd_back.sv
rtl/power_of_two_box_downsampler.sv
tb/box_average_checker.sv
tb/tb.sv
